### rtl/core/tomasulo_issue_scheduler_top_macros.svh
// Assertion macros used by the scheduler sequencer.
`ifndef TOMASULO_ISSUE_SCHEDULER_TOP_MACROS_SVH
`define TOMASULO_ISSUE_SCHEDULER_TOP_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define TIS_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Condition that must never be seen at a clock edge outside reset.
`define TIS_ASSERT_NEVER(lbl, cond, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) !(cond)) else $error(msg);

`endif

### rtl/core/tis_pkg.sv
// Types and constants shared by the issue scheduler modules.
`timescale 1ns / 1ps
package tis_pkg;

   localparam logic [2:0] CLS_INT   = 3'd0;
   localparam logic [2:0] CLS_LOAD  = 3'd1;
   localparam logic [2:0] CLS_STORE = 3'd2;
   localparam logic [2:0] CLS_FP    = 3'd3;

   localparam logic [3:0] INT_LAT_RESET = 4'd4;
   localparam logic [3:0] FP_LAT_RESET  = 4'd9;

   localparam logic CSR_INT_LAT = 1'b0;
   localparam logic CSR_FP_LAT  = 1'b1;

   typedef struct packed {
      logic [2:0]  cls;
      logic [15:0] idx;
      logic [5:0]  src_a;
      logic [5:0]  src_b;
      logic [5:0]  src_c;
      logic [2:0]  src_used;
      logic [5:0]  dst_a;
      logic [5:0]  dst_b;
      logic [1:0]  dst_used;
   } qentry_type;

   typedef struct packed {
      logic        valid;
      logic        started;
      logic [15:0] idx;
      logic [2:0]  cls;
      logic [5:0]  dst0;
      logic [5:0]  dst1;
      logic [1:0]  dst_used;
      logic [2:0]  tv;
      logic [15:0] tag0;
      logic [15:0] tag1;
      logic [15:0] tag2;
   } station_type;

   typedef struct packed {
      logic capture;
      logic wake;
      logic ret_chk0;
      logic ret_chk1;
      logic exec;
      logic issue;
      logic disp_head;
      logic disp_src0;
      logic disp_src1;
      logic disp_src2;
      logic disp_dst1;
      logic fetch;
   } cmd_type;

   typedef struct packed {
      logic bus_v;
      logic head_go;
   } status_type;

endpackage

### rtl/core/tis_ctrl.sv
// Tick sequencer: steps the datapath through the stages of one tick.
`timescale 1ns / 1ps
`include "tomasulo_issue_scheduler_top_macros.svh"
module tis_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   output logic                rsp_valid,
   input  tis_pkg::status_type status,
   output tis_pkg::cmd_type    cmd
);

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_RET0  = 4'd1;
   localparam logic [3:0] S_RET1  = 4'd2;
   localparam logic [3:0] S_RET2  = 4'd3;
   localparam logic [3:0] S_EXEC  = 4'd4;
   localparam logic [3:0] S_ISSUE = 4'd5;
   localparam logic [3:0] S_DISP0 = 4'd6;
   localparam logic [3:0] S_DS1   = 4'd7;
   localparam logic [3:0] S_DS2   = 4'd8;
   localparam logic [3:0] S_DS3   = 4'd9;
   localparam logic [3:0] S_DS4   = 4'd10;
   localparam logic [3:0] S_FETCH = 4'd11;
   localparam logic [3:0] S_RESP  = 4'd12;

   logic [3:0] state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.capture = 1'b1;
               state_in    = status.bus_v ? S_RET0 : S_EXEC;
            end
         end
         S_RET0: begin
            cmd.wake = 1'b1;
            state_in = S_RET1;
         end
         S_RET1: begin
            cmd.ret_chk0 = 1'b1;
            state_in     = S_RET2;
         end
         S_RET2: begin
            cmd.ret_chk1 = 1'b1;
            state_in     = S_EXEC;
         end
         S_EXEC: begin
            cmd.exec = 1'b1;
            state_in = S_ISSUE;
         end
         S_ISSUE: begin
            cmd.issue = 1'b1;
            state_in  = S_DISP0;
         end
         S_DISP0: begin
            cmd.disp_head = 1'b1;
            state_in      = status.head_go ? S_DS1 : S_FETCH;
         end
         S_DS1: begin
            cmd.disp_src0 = 1'b1;
            state_in      = S_DS2;
         end
         S_DS2: begin
            cmd.disp_src1 = 1'b1;
            state_in      = S_DS3;
         end
         S_DS3: begin
            cmd.disp_src2 = 1'b1;
            state_in      = S_DS4;
         end
         S_DS4: begin
            cmd.disp_dst1 = 1'b1;
            state_in      = S_FETCH;
         end
         S_FETCH: begin
            cmd.fetch = 1'b1;
            state_in  = S_RESP;
         end
         S_RESP: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = (state_ff == S_RESP);

   `TIS_ASSERT(a_cmd_onehot, $onehot0(cmd), "more than one datapath step commanded")
   `TIS_ASSERT(a_resp_then_idle, (state_ff == S_RESP) |=> (state_ff == S_IDLE), "tick did not end after its word")
   `TIS_ASSERT(a_accept_busy, (start && !busy) |=> (busy && !rsp_valid), "accepted tick did not start")
   `TIS_ASSERT_NEVER(a_fetch_once, cmd.fetch && $past(cmd.fetch), "fetch step repeated")

endmodule

### rtl/core/tis_dp.sv
// Scheduler datapath: queue, stations, units, rename table and bus holder.
`timescale 1ns / 1ps
module tis_dp #(
   parameter int QUEUE_DEPTH  = 10,
   parameter int INT_STATIONS = 4,
   parameter int FP_STATIONS  = 2,
   parameter int INT_UNITS    = 2,
   parameter int FP_UNITS     = 1,
   parameter int REG_COUNT    = 64
) (
   input  logic                clock,
   input  logic                reset,
   input  tis_pkg::cmd_type    cmd,
   output tis_pkg::status_type status,
   input  logic                csr_we,
   input  logic                csr_index,
   input  logic [3:0]          csr_wdata,
   input  logic                req_new_valid,
   input  logic [2:0]          req_instr_class,
   input  logic [15:0]         req_seq_index,
   input  logic [5:0]          req_src_reg_a,
   input  logic [5:0]          req_src_reg_b,
   input  logic [5:0]          req_src_reg_c,
   input  logic [2:0]          req_src_used,
   input  logic [5:0]          req_dst_reg_a,
   input  logic [5:0]          req_dst_reg_b,
   input  logic [1:0]          req_dst_used,
   output logic                rsp_fetch_accepted,
   output logic                rsp_dispatch_valid,
   output logic [15:0]         rsp_dispatch_index,
   output logic [2:0]          rsp_exec_start_mask,
   output logic                rsp_cdb_valid,
   output logic [15:0]         rsp_cdb_index,
   output logic [1:0]          rsp_stores_done,
   output logic                rsp_pipeline_empty
);

   localparam int QP_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QC_W = $clog2(QUEUE_DEPTH + 1);
   localparam int IS_W = (INT_STATIONS > 1) ? $clog2(INT_STATIONS) : 1;
   localparam int FS_W = (FP_STATIONS > 1) ? $clog2(FP_STATIONS) : 1;
   localparam int SL_W = (IS_W > FS_W) ? IS_W : FS_W;
   localparam int IU_W = (INT_UNITS > 1) ? $clog2(INT_UNITS) : 1;
   localparam int FU_W = (FP_UNITS > 1) ? $clog2(FP_UNITS) : 1;
   localparam int RA_W = $clog2(REG_COUNT);

   function automatic logic reg_ok(input logic [5:0] r);
      reg_ok = (32'(r) < REG_COUNT);
   endfunction

   // Configuration.
   logic [3:0] int_lat_ff, fp_lat_ff;

   // Instruction queue, a ring with undefined contents until written.
   tis_pkg::qentry_type q_mem[QUEUE_DEPTH];
   logic [QP_W-1:0] q_head_ff, q_head_in, q_tail, q_head_next;
   logic [QC_W-1:0] q_count_ff, q_count_in;
   logic [QP_W:0]   q_sum;
   logic            q_full;
   tis_pkg::qentry_type head_q;

   // Latched tick word.
   tis_pkg::qentry_type req_ff, req_in;
   logic                req_new_ff, req_new_in;

   // Stations and units.
   tis_pkg::station_type ist_ff[INT_STATIONS], ist_in[INT_STATIONS];
   tis_pkg::station_type fst_ff[FP_STATIONS], fst_in[FP_STATIONS];
   logic            iu_busy_ff[INT_UNITS], iu_busy_in[INT_UNITS];
   logic [IS_W-1:0] iu_slot_ff[INT_UNITS], iu_slot_in[INT_UNITS];
   logic [3:0]      iu_cnt_ff[INT_UNITS], iu_cnt_in[INT_UNITS];
   logic            fu_busy_ff[FP_UNITS], fu_busy_in[FP_UNITS];
   logic [FS_W-1:0] fu_slot_ff[FP_UNITS], fu_slot_in[FP_UNITS];
   logic [3:0]      fu_cnt_ff[FP_UNITS], fu_cnt_in[FP_UNITS];

   // Bus holder from the previous tick.
   logic        bus_v_ff, bus_v_in;
   logic [15:0] bus_idx_ff, bus_idx_in;
   logic [5:0]  bus_dst0_ff, bus_dst0_in, bus_dst1_ff, bus_dst1_in;
   logic [1:0]  bus_used_ff, bus_used_in;

   // Rename table: valid bits in flops, tags in a memory.
   logic            ren_v_ff[REG_COUNT], ren_v_in[REG_COUNT];
   logic [15:0]     ren_tag_mem[REG_COUNT];
   logic [15:0]     ren_rd_ff;
   logic [RA_W-1:0] ren_ra, ren_wa;
   logic [15:0]     ren_wd;
   logic            ren_we;

   // Dispatch scratch.
   logic [SL_W-1:0] disp_slot_ff, disp_slot_in;
   logic [1:0]      disp_tv_ff, disp_tv_in;
   logic [15:0]     disp_tag0_ff, disp_tag0_in, disp_tag1_ff, disp_tag1_in;
   logic            int_free, fp_free;
   logic [IS_W-1:0] int_free_idx;
   logic [FS_W-1:0] fp_free_idx;

   // Result word.
   logic        fetch_ok_ff, fetch_ok_in, disp_v_ff, disp_v_in;
   logic [15:0] disp_idx_ff, disp_idx_in, cdb_idx_ff, cdb_idx_in;
   logic [2:0]  start_ff, start_in;
   logic        cdb_v_ff, cdb_v_in;
   logic [1:0]  stores_ff, stores_in;

   assign head_q      = q_mem[q_head_ff];
   assign q_sum       = {1'b0, q_head_ff} + (QP_W + 1)'(q_count_ff);
   assign q_tail      = (q_sum >= (QP_W + 1)'(QUEUE_DEPTH)) ?
                        QP_W'(q_sum - (QP_W + 1)'(QUEUE_DEPTH)) : QP_W'(q_sum);
   assign q_head_next = (q_head_ff == QP_W'(QUEUE_DEPTH - 1)) ? '0 : q_head_ff + 1'b1;
   assign q_full      = (q_count_ff >= QC_W'(QUEUE_DEPTH));

   always_comb begin
      int_free     = 1'b0;
      int_free_idx = '0;
      for (int j = INT_STATIONS - 1; j >= 0; j--) begin
         if (!ist_ff[j].valid) begin
            int_free     = 1'b1;
            int_free_idx = IS_W'(j);
         end
      end
      fp_free     = 1'b0;
      fp_free_idx = '0;
      for (int j = FP_STATIONS - 1; j >= 0; j--) begin
         if (!fst_ff[j].valid) begin
            fp_free     = 1'b1;
            fp_free_idx = FS_W'(j);
         end
      end
   end

   assign status.bus_v   = bus_v_ff;
   assign status.head_go = (q_count_ff != '0) && (head_q.cls <= tis_pkg::CLS_FP) &&
                           ((head_q.cls == tis_pkg::CLS_FP) ? fp_free : int_free);

   always_comb begin
      ren_ra = '0;
      if (cmd.wake) begin
         ren_ra = RA_W'(bus_dst0_ff);
      end else if (cmd.ret_chk0) begin
         ren_ra = RA_W'(bus_dst1_ff);
      end else if (cmd.disp_head) begin
         ren_ra = RA_W'(head_q.src_a);
      end else if (cmd.disp_src0) begin
         ren_ra = RA_W'(head_q.src_b);
      end else if (cmd.disp_src1) begin
         ren_ra = RA_W'(head_q.src_c);
      end
   end

   always_comb begin : next_state
      logic                 found, best_fp, stop, got_u, sb0, sb1, sb2, tv2;
      logic [IU_W-1:0]      best_iu;
      logic [FU_W-1:0]      best_fu;
      logic [15:0]          best_idx;
      logic [IS_W-1:0]      islot;
      logic [FS_W-1:0]      fslot;
      logic [1:0]           st_cnt;
      tis_pkg::station_type win, nst;

      found = 1'b0; best_fp = 1'b0; stop = 1'b0; got_u = 1'b0;
      sb0 = 1'b0; sb1 = 1'b0; sb2 = 1'b0; tv2 = 1'b0;
      best_iu = '0; best_fu = '0; best_idx = '0; islot = '0; fslot = '0;
      st_cnt = '0; win = '0; nst = '0;

      req_in = req_ff; req_new_in = req_new_ff;
      q_head_in = q_head_ff; q_count_in = q_count_ff;
      ist_in = ist_ff; fst_in = fst_ff;
      iu_busy_in = iu_busy_ff; iu_slot_in = iu_slot_ff; iu_cnt_in = iu_cnt_ff;
      fu_busy_in = fu_busy_ff; fu_slot_in = fu_slot_ff; fu_cnt_in = fu_cnt_ff;
      bus_v_in = bus_v_ff; bus_idx_in = bus_idx_ff;
      bus_dst0_in = bus_dst0_ff; bus_dst1_in = bus_dst1_ff; bus_used_in = bus_used_ff;
      ren_v_in = ren_v_ff;
      ren_we = 1'b0; ren_wa = '0; ren_wd = head_q.idx;
      disp_slot_in = disp_slot_ff; disp_tv_in = disp_tv_ff;
      disp_tag0_in = disp_tag0_ff; disp_tag1_in = disp_tag1_ff;
      fetch_ok_in = fetch_ok_ff; disp_v_in = disp_v_ff; disp_idx_in = disp_idx_ff;
      start_in = start_ff; cdb_v_in = cdb_v_ff; cdb_idx_in = cdb_idx_ff;
      stores_in = stores_ff;

      if (cmd.capture) begin
         req_new_in = req_new_valid;
         req_in = '{cls: req_instr_class, idx: req_seq_index, src_a: req_src_reg_a,
                    src_b: req_src_reg_b, src_c: req_src_reg_c, src_used: req_src_used,
                    dst_a: req_dst_reg_a, dst_b: req_dst_reg_b, dst_used: req_dst_used};
         fetch_ok_in = 1'b0; disp_v_in = 1'b0; disp_idx_in = '0; start_in = '0;
         cdb_v_in = 1'b0; cdb_idx_in = '0; stores_in = '0;
      end

      if (cmd.wake) begin
         for (int j = 0; j < INT_STATIONS; j++) begin
            if (ist_ff[j].valid) begin
               if (ist_ff[j].tv[0] && ist_ff[j].tag0 == bus_idx_ff) ist_in[j].tv[0] = 1'b0;
               if (ist_ff[j].tv[1] && ist_ff[j].tag1 == bus_idx_ff) ist_in[j].tv[1] = 1'b0;
               if (ist_ff[j].tv[2] && ist_ff[j].tag2 == bus_idx_ff) ist_in[j].tv[2] = 1'b0;
            end
         end
         for (int j = 0; j < FP_STATIONS; j++) begin
            if (fst_ff[j].valid) begin
               if (fst_ff[j].tv[0] && fst_ff[j].tag0 == bus_idx_ff) fst_in[j].tv[0] = 1'b0;
               if (fst_ff[j].tv[1] && fst_ff[j].tag1 == bus_idx_ff) fst_in[j].tv[1] = 1'b0;
               if (fst_ff[j].tv[2] && fst_ff[j].tag2 == bus_idx_ff) fst_in[j].tv[2] = 1'b0;
            end
         end
      end

      if (cmd.ret_chk0 && bus_used_ff[0] && reg_ok(bus_dst0_ff)) begin
         if (ren_v_ff[RA_W'(bus_dst0_ff)] && ren_rd_ff == bus_idx_ff) begin
            ren_v_in[RA_W'(bus_dst0_ff)] = 1'b0;
         end
      end
      if (cmd.ret_chk1) begin
         bus_v_in = 1'b0;
         if (bus_used_ff[1] && reg_ok(bus_dst1_ff)) begin
            if (ren_v_ff[RA_W'(bus_dst1_ff)] && ren_rd_ff == bus_idx_ff) begin
               ren_v_in[RA_W'(bus_dst1_ff)] = 1'b0;
            end
         end
      end

      if (cmd.exec) begin
         for (int i = 0; i < INT_UNITS; i++) begin
            if (iu_busy_in[i] && iu_cnt_in[i] != 4'd0) iu_cnt_in[i] = iu_cnt_in[i] - 4'd1;
         end
         for (int i = 0; i < FP_UNITS; i++) begin
            if (fu_busy_in[i] && fu_cnt_in[i] != 4'd0) fu_cnt_in[i] = fu_cnt_in[i] - 4'd1;
         end
         for (int i = 0; i < INT_UNITS; i++) begin
            if (iu_busy_in[i] && iu_cnt_in[i] == 4'd0) begin
               if (ist_in[iu_slot_in[i]].cls == tis_pkg::CLS_STORE) begin
                  ist_in[iu_slot_in[i]] = '0;
                  iu_busy_in[i] = 1'b0;
                  if (st_cnt != 2'd3) st_cnt = st_cnt + 2'd1;
               end else if (!found || best_idx > ist_in[iu_slot_in[i]].idx) begin
                  found    = 1'b1;
                  best_fp  = 1'b0;
                  best_iu  = IU_W'(i);
                  best_idx = ist_in[iu_slot_in[i]].idx;
               end
            end
         end
         for (int i = 0; i < FP_UNITS; i++) begin
            if (fu_busy_in[i] && fu_cnt_in[i] == 4'd0) begin
               if (!found || best_idx > fst_in[fu_slot_in[i]].idx) begin
                  found    = 1'b1;
                  best_fp  = 1'b1;
                  best_fu  = FU_W'(i);
                  best_idx = fst_in[fu_slot_in[i]].idx;
               end
            end
         end
         stores_in = st_cnt;
         if (found) begin
            if (best_fp) begin
               fslot = fu_slot_in[best_fu];
               win   = fst_in[fslot];
               fu_busy_in[best_fu] = 1'b0;
               fu_cnt_in[best_fu]  = 4'd0;
               for (int j = 0; j < FP_STATIONS - 1; j++) begin
                  if (FS_W'(j) >= fslot) fst_in[j] = fst_in[j + 1];
               end
               fst_in[FP_STATIONS - 1] = '0;
               for (int i = 0; i < FP_UNITS; i++) begin
                  if (fu_busy_in[i] && fu_slot_in[i] > fslot) fu_slot_in[i] = fu_slot_in[i] - 1'b1;
               end
            end else begin
               islot = iu_slot_in[best_iu];
               win   = ist_in[islot];
               iu_busy_in[best_iu] = 1'b0;
               iu_cnt_in[best_iu]  = 4'd0;
               for (int j = 0; j < INT_STATIONS - 1; j++) begin
                  if (IS_W'(j) >= islot) ist_in[j] = ist_in[j + 1];
               end
               ist_in[INT_STATIONS - 1] = '0;
               for (int i = 0; i < INT_UNITS; i++) begin
                  if (iu_busy_in[i] && iu_slot_in[i] > islot) iu_slot_in[i] = iu_slot_in[i] - 1'b1;
               end
            end
            bus_v_in    = 1'b1;
            bus_idx_in  = win.idx;
            bus_dst0_in = win.dst0;
            bus_dst1_in = win.dst1;
            bus_used_in = win.dst_used;
            cdb_v_in    = 1'b1;
            cdb_idx_in  = win.idx;
         end
      end

      if (cmd.issue) begin
         for (int j = 0; j < INT_STATIONS; j++) begin
            if (!stop && ist_ff[j].valid && !ist_ff[j].started && ist_ff[j].tv == 3'b000) begin
               got_u = 1'b0;
               for (int k = 0; k < INT_UNITS; k++) begin
                  if (!got_u && !iu_busy_in[k]) begin
                     got_u         = 1'b1;
                     iu_busy_in[k] = 1'b1;
                     iu_slot_in[k] = IS_W'(j);
                     iu_cnt_in[k]  = int_lat_ff;
                     if (k == 0) sb0 = 1'b1;
                     else sb1 = 1'b1;
                  end
               end
               if (got_u) ist_in[j].started = 1'b1;
               else stop = 1'b1;
            end
         end
         stop = 1'b0;
         for (int j = 0; j < FP_STATIONS; j++) begin
            if (!stop && fst_ff[j].valid && !fst_ff[j].started && fst_ff[j].tv == 3'b000) begin
               got_u = 1'b0;
               for (int k = 0; k < FP_UNITS; k++) begin
                  if (!got_u && !fu_busy_in[k]) begin
                     got_u         = 1'b1;
                     fu_busy_in[k] = 1'b1;
                     fu_slot_in[k] = FS_W'(j);
                     fu_cnt_in[k]  = fp_lat_ff;
                     sb2           = 1'b1;
                  end
               end
               if (got_u) fst_in[j].started = 1'b1;
               else stop = 1'b1;
            end
         end
         start_in = {sb2, sb1, sb0};
      end

      if (cmd.disp_head) begin
         disp_slot_in = (head_q.cls == tis_pkg::CLS_FP) ? SL_W'(fp_free_idx) : SL_W'(int_free_idx);
         if (q_count_ff != '0 && head_q.cls > tis_pkg::CLS_FP) begin
            q_head_in  = q_head_next;
            q_count_in = q_count_ff - 1'b1;
         end
      end
      if (cmd.disp_src0) begin
         disp_tv_in[0] = head_q.src_used[0] && reg_ok(head_q.src_a) &&
                         ren_v_ff[RA_W'(head_q.src_a)];
         disp_tag0_in  = ren_rd_ff;
      end
      if (cmd.disp_src1) begin
         disp_tv_in[1] = head_q.src_used[1] && reg_ok(head_q.src_b) &&
                         ren_v_ff[RA_W'(head_q.src_b)];
         disp_tag1_in  = ren_rd_ff;
      end
      if (cmd.disp_src2) begin
         tv2 = head_q.src_used[2] && reg_ok(head_q.src_c) && ren_v_ff[RA_W'(head_q.src_c)];
         nst.valid = 1'b1;
         nst.idx   = head_q.idx;
         nst.cls   = head_q.cls;
         nst.tv    = {tv2, disp_tv_ff};
         nst.tag0  = disp_tv_ff[0] ? disp_tag0_ff : 16'd0;
         nst.tag1  = disp_tv_ff[1] ? disp_tag1_ff : 16'd0;
         nst.tag2  = tv2 ? ren_rd_ff : 16'd0;
         if (head_q.cls != tis_pkg::CLS_STORE) begin
            if (head_q.dst_used[0] && reg_ok(head_q.dst_a)) begin
               nst.dst0 = head_q.dst_a;
               nst.dst_used[0] = 1'b1;
               ren_v_in[RA_W'(head_q.dst_a)] = 1'b1;
               ren_we = 1'b1;
               ren_wa = RA_W'(head_q.dst_a);
            end
            if (head_q.dst_used[1] && reg_ok(head_q.dst_b)) begin
               nst.dst1 = head_q.dst_b;
               nst.dst_used[1] = 1'b1;
            end
         end
         if (head_q.cls == tis_pkg::CLS_FP) fst_in[disp_slot_ff[FS_W-1:0]] = nst;
         else ist_in[disp_slot_ff[IS_W-1:0]] = nst;
      end
      if (cmd.disp_dst1) begin
         if (head_q.cls != tis_pkg::CLS_STORE && head_q.dst_used[1] && reg_ok(head_q.dst_b)) begin
            ren_v_in[RA_W'(head_q.dst_b)] = 1'b1;
            ren_we = 1'b1;
            ren_wa = RA_W'(head_q.dst_b);
         end
         disp_v_in   = 1'b1;
         disp_idx_in = head_q.idx;
         q_head_in   = q_head_next;
         q_count_in  = q_count_ff - 1'b1;
      end

      if (cmd.fetch && req_new_ff && !q_full) begin
         q_count_in  = q_count_ff + 1'b1;
         fetch_ok_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         int_lat_ff <= tis_pkg::INT_LAT_RESET;
         fp_lat_ff  <= tis_pkg::FP_LAT_RESET;
         q_head_ff  <= '0;
         q_count_ff <= '0;
         bus_v_ff   <= 1'b0;
         for (int j = 0; j < INT_STATIONS; j++) ist_ff[j] <= '0;
         for (int j = 0; j < FP_STATIONS; j++) fst_ff[j] <= '0;
         for (int i = 0; i < INT_UNITS; i++) begin
            iu_busy_ff[i] <= 1'b0;
            iu_slot_ff[i] <= '0;
            iu_cnt_ff[i]  <= '0;
         end
         for (int i = 0; i < FP_UNITS; i++) begin
            fu_busy_ff[i] <= 1'b0;
            fu_slot_ff[i] <= '0;
            fu_cnt_ff[i]  <= '0;
         end
         for (int r = 0; r < REG_COUNT; r++) ren_v_ff[r] <= 1'b0;
      end else begin
         if (csr_we && csr_index == tis_pkg::CSR_INT_LAT) int_lat_ff <= csr_wdata;
         if (csr_we && csr_index == tis_pkg::CSR_FP_LAT) fp_lat_ff <= csr_wdata;
         q_head_ff  <= q_head_in;
         q_count_ff <= q_count_in;
         bus_v_ff   <= bus_v_in;
         ist_ff     <= ist_in;
         fst_ff     <= fst_in;
         iu_busy_ff <= iu_busy_in;
         iu_slot_ff <= iu_slot_in;
         iu_cnt_ff  <= iu_cnt_in;
         fu_busy_ff <= fu_busy_in;
         fu_slot_ff <= fu_slot_in;
         fu_cnt_ff  <= fu_cnt_in;
         ren_v_ff   <= ren_v_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff       <= req_in;
      req_new_ff   <= req_new_in;
      bus_idx_ff   <= bus_idx_in;
      bus_dst0_ff  <= bus_dst0_in;
      bus_dst1_ff  <= bus_dst1_in;
      bus_used_ff  <= bus_used_in;
      disp_slot_ff <= disp_slot_in;
      disp_tv_ff   <= disp_tv_in;
      disp_tag0_ff <= disp_tag0_in;
      disp_tag1_ff <= disp_tag1_in;
      fetch_ok_ff  <= fetch_ok_in;
      disp_v_ff    <= disp_v_in;
      disp_idx_ff  <= disp_idx_in;
      start_ff     <= start_in;
      cdb_v_ff     <= cdb_v_in;
      cdb_idx_ff   <= cdb_idx_in;
      stores_ff    <= stores_in;
      if (cmd.fetch && req_new_ff && !q_full) q_mem[q_tail] <= req_ff;
   end

   always_ff @(posedge clock) begin
      if (ren_we) ren_tag_mem[ren_wa] <= ren_wd;
      ren_rd_ff <= ren_tag_mem[ren_ra];
   end

   always_comb begin
      rsp_pipeline_empty = (q_count_ff == '0);
      for (int j = 0; j < INT_STATIONS; j++) if (ist_ff[j].valid) rsp_pipeline_empty = 1'b0;
      for (int j = 0; j < FP_STATIONS; j++) if (fst_ff[j].valid) rsp_pipeline_empty = 1'b0;
      for (int i = 0; i < INT_UNITS; i++) if (iu_busy_ff[i]) rsp_pipeline_empty = 1'b0;
      for (int i = 0; i < FP_UNITS; i++) if (fu_busy_ff[i]) rsp_pipeline_empty = 1'b0;
   end

   assign rsp_fetch_accepted  = fetch_ok_ff;
   assign rsp_dispatch_valid  = disp_v_ff;
   assign rsp_dispatch_index  = disp_idx_ff;
   assign rsp_exec_start_mask = start_ff;
   assign rsp_cdb_valid       = cdb_v_ff;
   assign rsp_cdb_index       = cdb_idx_ff;
   assign rsp_stores_done     = stores_ff;

endmodule

### rtl/core/tomasulo_issue_scheduler_top.sv
// Top level of the Tomasulo issue scheduler timing model.
//
//   channel   ports                           handshake
//   -------   -----------------------------   ------------------------------
//   request   start, busy, req_*              taken when start high, busy low
//   response  rsp_valid, rsp_*                one-cycle strobe, no back-pressure
//   config    csr_we, csr_index, csr_wdata    written when csr_we high
//
// Each request word is one machine tick: execute, issue, dispatch head, fetch
// and response states, after retire states RET0-RET2 when an instruction held
// the data bus in the previous tick, with DS1-DS4 after the dispatch head when
// the queue head is dispatched. The extra states come from the single read port
// of the rename tag memory, serving two retire and three source lookups in turn.
// busy stays high from the accept until the strobe cycle ends.
// Synchronous reset empties the queue, stations, units and rename table and loads
// the latency registers with their tis_pkg reset values; no clearing pass is needed.
// The receiver cannot stall; a word is presented for exactly one cycle.
`timescale 1ns / 1ps
module tomasulo_issue_scheduler_top #(
   parameter int QUEUE_DEPTH  = 10,
   parameter int INT_STATIONS = 4,
   parameter int FP_STATIONS  = 2,
   parameter int INT_UNITS    = 2,
   parameter int FP_UNITS     = 1,
   parameter int REG_COUNT    = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_new_valid,
   input  logic [2:0]  req_instr_class,
   input  logic [15:0] req_seq_index,
   input  logic [5:0]  req_src_reg_a,
   input  logic [5:0]  req_src_reg_b,
   input  logic [5:0]  req_src_reg_c,
   input  logic [2:0]  req_src_used,
   input  logic [5:0]  req_dst_reg_a,
   input  logic [5:0]  req_dst_reg_b,
   input  logic [1:0]  req_dst_used,
   output logic        rsp_valid,
   output logic        rsp_fetch_accepted,
   output logic        rsp_dispatch_valid,
   output logic [15:0] rsp_dispatch_index,
   output logic [2:0]  rsp_exec_start_mask,
   output logic        rsp_cdb_valid,
   output logic [15:0] rsp_cdb_index,
   output logic [1:0]  rsp_stores_done,
   output logic        rsp_pipeline_empty,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [3:0]  csr_wdata
);

   // The sequencer issues at most one step command per cycle; the datapath reports
   // whether a bus holder must retire and whether the queue head can dispatch.
   tis_pkg::cmd_type    cmd;
   tis_pkg::status_type status;

   tis_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .status    (status),
      .cmd       (cmd)
   );

   tis_dp #(
      .QUEUE_DEPTH  (QUEUE_DEPTH),
      .INT_STATIONS (INT_STATIONS),
      .FP_STATIONS  (FP_STATIONS),
      .INT_UNITS    (INT_UNITS),
      .FP_UNITS     (FP_UNITS),
      .REG_COUNT    (REG_COUNT)
   ) u_dp (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .status              (status),
      .csr_we              (csr_we),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata),
      .req_new_valid       (req_new_valid),
      .req_instr_class     (req_instr_class),
      .req_seq_index       (req_seq_index),
      .req_src_reg_a       (req_src_reg_a),
      .req_src_reg_b       (req_src_reg_b),
      .req_src_reg_c       (req_src_reg_c),
      .req_src_used        (req_src_used),
      .req_dst_reg_a       (req_dst_reg_a),
      .req_dst_reg_b       (req_dst_reg_b),
      .req_dst_used        (req_dst_used),
      .rsp_fetch_accepted  (rsp_fetch_accepted),
      .rsp_dispatch_valid  (rsp_dispatch_valid),
      .rsp_dispatch_index  (rsp_dispatch_index),
      .rsp_exec_start_mask (rsp_exec_start_mask),
      .rsp_cdb_valid       (rsp_cdb_valid),
      .rsp_cdb_index       (rsp_cdb_index),
      .rsp_stores_done     (rsp_stores_done),
      .rsp_pipeline_empty  (rsp_pipeline_empty)
   );

endmodule
